// ===== hw/rtl/glyph_quad_generator_top_macros.svh =====
// Assertion macros shared by the glyph quad generator.
`ifndef GLYPH_QUAD_GENERATOR_TOP_MACROS_SVH
`define GLYPH_QUAD_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define GQG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define GQG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gqg_pkg.sv =====
// ----------------------------------------------------------------------------
// gqg_pkg
// Types, codes and constants of the glyph quad generator.
// ----------------------------------------------------------------------------
package gqg_pkg;

    localparam int GLYPH_SLOTS = 256;
    localparam int SLOT_W      = $clog2(GLYPH_SLOTS);
    localparam int NUM_W       = 36;
    localparam int DEN_W       = 13;
    localparam int STEPS       = 9;
    localparam int RESULTS     = 10;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_DRAW   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic KIND_INDEX  = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    localparam logic [1:0] REG_TEX_WIDTH   = 2'd0;
    localparam logic [1:0] REG_TEX_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_TEXT_HEIGHT = 2'd2;

    localparam logic [3:0] STEP_X0  = 4'd0;
    localparam logic [3:0] STEP_X1  = 4'd1;
    localparam logic [3:0] STEP_Y0  = 4'd2;
    localparam logic [3:0] STEP_Y1  = 4'd3;
    localparam logic [3:0] STEP_ADV = 4'd4;
    localparam logic [3:0] STEP_U0  = 4'd5;
    localparam logic [3:0] STEP_U1  = 4'd6;
    localparam logic [3:0] STEP_V0  = 4'd7;
    localparam logic [3:0] STEP_V1  = 4'd8;

    localparam logic signed [36:0] POS_MAX = 37'sd8388607;
    localparam logic signed [36:0] POS_MIN = -37'sd8388608;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         char_code;
        logic [11:0]        atlas_x;
        logic [11:0]        atlas_y;
        logic [11:0]        glyph_w;
        logic [11:0]        glyph_h;
        logic signed [11:0] bearing_x;
        logic signed [11:0] bearing_y;
        logic [11:0]        cell_w;
        logic [11:0]        cell_h;
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
    } cmd_t;

    typedef struct packed {
        logic               item_kind;
        logic [15:0]        index_value;
        logic signed [23:0] vert_x;
        logic signed [23:0] vert_y;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [11:0]        ax;
        logic signed [14:0] ay;
        logic [11:0]        gw;
        logic [11:0]        gh;
        logic signed [11:0] bx;
        logic signed [13:0] oy;
        logic [11:0]        cw;
        logic [11:0]        ch;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [SLOT_W-1:0] addr;
        entry_t            wdata;
    } tbl_req_t;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [NUM_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIVS,
        S_DIVW,
        S_EMIT
    } state_t;

    function automatic logic [15:0] idx_offset(input logic [3:0] cnt);
        logic [15:0] r;
        case (cnt)
            4'd1, 4'd4: r = 16'd1;
            4'd2, 4'd3: r = 16'd2;
            4'd5:       r = 16'd3;
            default:    r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/gqg_table.sv =====
// ----------------------------------------------------------------------------
// gqg_table
// Glyph entry memory with one write and one registered read port, plus the
// per-slot valid flags.
// ----------------------------------------------------------------------------
module gqg_table
    import gqg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tbl_req_t req,
    output logic     valid,
    output entry_t   rd_data
);

    entry_t                 mem [GLYPH_SLOTS];
    logic [GLYPH_SLOTS-1:0] valid_reg;

    assign valid = valid_reg[req.addr];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.we)
        begin
            valid_reg[req.addr] <= 1'b1;
        end
    end

endmodule

// ===== hw/rtl/gqg_div.sv =====
// ----------------------------------------------------------------------------
// gqg_div
// Restoring divider, one quotient bit per cycle, rounding half away from zero.
// ----------------------------------------------------------------------------
module gqg_div
    import gqg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int MAG_W = NUM_W + 1;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0] dvd_reg, dvd_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [NUM_W-1:0] mag;
    logic [DEN_W:0]   trial;
    logic [MAG_W-1:0] qneg;

    assign mag   = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    assign trial = {rem_reg[DEN_W-1:0], dvd_reg[MAG_W-1]};

    always_comb
    begin
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = trial - {1'b0, den_reg};
            dvd_next = {dvd_reg[MAG_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial;
            dvd_next = {dvd_reg[MAG_W-2:0], 1'b0};
        end
    end

    assign qneg     = neg_reg ? (~dvd_reg + 1'b1) : dvd_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = qneg[NUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(MAG_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= {1'b0, mag} + MAG_W'(req.den >> 1);
            rem_reg <= '0;
            den_reg <= req.den;
            neg_reg <= req.num[NUM_W-1];
        end
        else if (run_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// ===== hw/rtl/glyph_quad_generator_top.sv =====
// ----------------------------------------------------------------------------
// glyph_quad_generator_top
// Glyph table and quad layout sequencer for bitmap font text.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Loads (opcode 0) and
// pen starts (opcode 1) finish in the cycle they are taken and never raise
// busy. A draw (opcode 2) reads the glyph memory, then runs nine rounded
// divisions on one shared bit-serial divider of 37 steps each, then sends
// ten results, one per cycle, on result while strobe is high; last marks
// the tenth. A draw of a found glyph holds busy through one read state,
// nine divisions (operand multiply, divider start, the divider steps, done)
// and the emit cycles, so the divider sets the rate. Each result is
// registered and appears in the cycle after its emit cycle; the last one
// appears as busy falls, and the next item can be taken in that cycle.
// A draw of an unknown glyph finishes in the cycle it is taken; a zero cell
// height holds busy only for the read state. Neither sends results. The
// receiver cannot stall: each result is valid for exactly one cycle.
// Configuration writes via wr_en, wr_index and wr_data take effect at once
// and belong between items. Reset clears the valid flags, the pen and the
// vertex counter; the glyph memory contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module glyph_quad_generator_top
    import gqg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        strobe,
    output result_t     result,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data
);

`include "glyph_quad_generator_top_macros.svh"

    state_t                  state_reg, state_next;
    logic [12:0]             tex_width_reg, tex_height_reg;
    logic [15:0]             text_height_reg;
    logic signed [23:0]      pen_x_reg, pen_y_reg;
    logic [15:0]             vcount_reg;
    entry_t                  entry_reg;
    logic [3:0]              step_reg;
    logic [3:0]              cnt_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0]        den_reg;
    logic signed [NUM_W-1:0] q_reg [STEPS];
    result_t                 result_reg;
    logic                    strobe_reg;

    tbl_req_t                tbl_req;
    logic                    tbl_valid;
    entry_t                  tbl_data;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    logic                    accept;
    logic signed [14:0]      step_n;
    logic [20:0]             step_mult;
    logic [DEN_W-1:0]        step_den;
    logic signed [36:0]      prod;
    logic [12:0]             tw_eff, th_eff;
    logic [1:0]              vi;
    logic signed [NUM_W-1:0] sel_x, sel_y, sel_u, sel_v;
    logic signed [36:0]      sum_x, sum_y, sum_adv;
    result_t                 res_next;
    logic                    emit_done;

    function automatic logic signed [23:0] sat24(input logic signed [36:0] v);
        logic signed [23:0] r;
        if (v > POS_MAX)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < POS_MIN)
        begin
            r = -24'sh800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic [16:0] uvclamp(input logic signed [NUM_W-1:0] v);
        logic [16:0] r;
        if (v < 0)
        begin
            r = 17'd0;
        end
        else if (v > 65536)
        begin
            r = 17'd65536;
        end
        else
        begin
            r = v[16:0];
        end
        return r;
    endfunction

    assign accept = start && !busy;

    always_comb
    begin
        tbl_req.addr           = cmd.char_code[SLOT_W-1:0];
        tbl_req.re             = accept && (cmd.opcode == OP_DRAW);
        tbl_req.we             = accept && (cmd.opcode == OP_LOAD) && !tbl_valid;
        tbl_req.wdata.ax       = cmd.atlas_x;
        tbl_req.wdata.gw       = cmd.glyph_w;
        tbl_req.wdata.gh       = cmd.glyph_h;
        tbl_req.wdata.ay       = $signed({2'b00, tex_height_reg}) -
                                 $signed({3'b000, cmd.atlas_y}) -
                                 $signed({3'b000, cmd.glyph_h});
        tbl_req.wdata.bx       = cmd.bearing_x;
        tbl_req.wdata.cw       = cmd.cell_w;
        tbl_req.wdata.ch       = cmd.cell_h;
        tbl_req.wdata.oy       = $signed({2'b00, cmd.cell_h}) -
                                 $signed({2'b00, cmd.glyph_h}) -
                                 14'(cmd.bearing_y);
    end

    gqg_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .valid   (tbl_valid),
        .rd_data (tbl_data)
    );

    assign div_req.start = (state_reg == S_DIVS);
    assign div_req.num   = num_reg;
    assign div_req.den   = den_reg;

    gqg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign tw_eff = (tex_width_reg == '0) ? 13'd1 : tex_width_reg;
    assign th_eff = (tex_height_reg == '0) ? 13'd1 : tex_height_reg;

    always_comb
    begin
        step_mult = {1'b0, text_height_reg, 4'b0000};
        step_den  = {1'b0, entry_reg.ch};
        case (step_reg)
            STEP_X0:  step_n = 15'(entry_reg.bx);
            STEP_X1:  step_n = 15'(entry_reg.bx) + $signed({3'b000, entry_reg.gw});
            STEP_Y0:  step_n = 15'(entry_reg.oy);
            STEP_Y1:  step_n = 15'(entry_reg.oy) + $signed({3'b000, entry_reg.gh});
            STEP_ADV: step_n = $signed({3'b000, entry_reg.cw});
            STEP_U0:  step_n = $signed({3'b000, entry_reg.ax});
            STEP_U1:  step_n = $signed({3'b000, entry_reg.ax}) +
                               $signed({3'b000, entry_reg.gw});
            STEP_V0:  step_n = entry_reg.ay;
            default:  step_n = entry_reg.ay + $signed({3'b000, entry_reg.gh});
        endcase
        if (step_reg == STEP_U0 || step_reg == STEP_U1)
        begin
            step_mult = 21'd65536;
            step_den  = tw_eff;
        end
        else if (step_reg == STEP_V0 || step_reg == STEP_V1)
        begin
            step_mult = 21'd65536;
            step_den  = th_eff;
        end
    end

    assign prod = step_n * $signed({1'b0, step_mult});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.opcode == OP_DRAW) && tbl_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = (tbl_data.ch == '0) ? S_IDLE : S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    state_next = (step_reg == STEP_V1) ? S_EMIT : S_MUL;
                end
            end
            S_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign emit_done = (state_reg == S_EMIT) && (cnt_reg == 4'(RESULTS - 1));

    always_comb
    begin
        vi      = 2'(cnt_reg - 4'd6);
        sel_x   = vi[1] ? q_reg[STEP_X1] : q_reg[STEP_X0];
        sel_u   = vi[1] ? q_reg[STEP_U1] : q_reg[STEP_U0];
        sel_y   = vi[0] ? q_reg[STEP_Y0] : q_reg[STEP_Y1];
        sel_v   = vi[0] ? q_reg[STEP_V0] : q_reg[STEP_V1];
        sum_x   = 37'(pen_x_reg) + 37'(sel_x);
        sum_y   = 37'(pen_y_reg) + 37'(sel_y);
        sum_adv = 37'(pen_x_reg) + 37'(q_reg[STEP_ADV]);
        res_next = '0;
        if (cnt_reg < 4'd6)
        begin
            res_next.item_kind   = KIND_INDEX;
            res_next.index_value = vcount_reg + idx_offset(cnt_reg);
        end
        else
        begin
            res_next.item_kind = KIND_VERTEX;
            res_next.vert_x    = sat24(sum_x);
            res_next.vert_y    = sat24(sum_y);
            res_next.tex_u     = uvclamp(sel_u);
            res_next.tex_v     = uvclamp(sel_v);
            res_next.last      = (cnt_reg == 4'(RESULTS - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            tex_width_reg   <= 13'd256;
            tex_height_reg  <= 13'd256;
            text_height_reg <= 16'd256;
            pen_x_reg       <= '0;
            pen_y_reg       <= '0;
            vcount_reg      <= '0;
            step_reg        <= '0;
            cnt_reg         <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == S_EMIT);
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_TEX_WIDTH:   tex_width_reg   <= wr_data[12:0];
                    REG_TEX_HEIGHT:  tex_height_reg  <= wr_data[12:0];
                    REG_TEXT_HEIGHT: text_height_reg <= wr_data;
                    default:         ;
                endcase
            end
            if (accept && (cmd.opcode == OP_START))
            begin
                pen_x_reg  <= cmd.start_x;
                pen_y_reg  <= cmd.start_y;
                vcount_reg <= '0;
            end
            if (state_reg == S_READ)
            begin
                step_reg <= STEP_X0;
                cnt_reg  <= '0;
            end
            if ((state_reg == S_DIVW) && div_rsp.done)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (state_reg == S_EMIT)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (emit_done)
            begin
                vcount_reg <= vcount_reg + 16'd4;
                pen_x_reg  <= sat24(sum_adv);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            entry_reg <= tbl_data;
        end
        if (state_reg == S_MUL)
        begin
            num_reg <= prod[NUM_W-1:0];
            den_reg <= step_den;
        end
        if ((state_reg == S_DIVW) && div_rsp.done)
        begin
            q_reg[step_reg] <= div_rsp.quot;
        end
        if (state_reg == S_EMIT)
        begin
            result_reg <= res_next;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    `GQG_ASSERT_NEXT(a_last_ends_run, strobe && result.last, !strobe,
        "a result followed the last result of a run")
    `GQG_ASSERT_IMPL(a_last_is_vertex, strobe && result.last,
        result.item_kind == KIND_VERTEX, "last flag set on an index result")
    `GQG_ASSERT_NEXT(a_short_ops_idle, accept && (cmd.opcode != OP_DRAW), !busy,
        "a load or pen start made the block busy")

endmodule

// ===== dv/glyph_quad_generator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_quad_generator_checker
// Watches the command, result and register ports of the glyph quad generator.
// It keeps its own glyph table, pen and register copies, predicts the index
// and vertex results of every accepted draw, and compares each result in
// order. It reports the number of failures and of results still awaited.
// ----------------------------------------------------------------------------
module glyph_quad_generator_checker
    import gqg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  cmd_t        cmd,
    input  logic        strobe,
    input  result_t     result,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data,
    output int          fail_count,
    output int          pending
);

    localparam int EXP_DEPTH = 16;

    typedef struct {
        longint ax, ay, gw, gh, bx, oy, cw, ch;
    } glyph_t;

    glyph_t     glyphs [256];
    bit         glyph_loaded [256];
    longint     pen_x, pen_y;
    logic [15:0] vtx_count;
    logic [12:0] tex_w, tex_h;
    logic [15:0] txt_h;
    result_t    exp_buf [EXP_DEPTH];
    logic [3:0] exp_wr_ptr;
    logic [3:0] exp_rd_ptr;
    int         exp_fill;

    function automatic longint round_div(longint num, longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clamp_pos(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint clamp_uv(longint v);
        if (v < 0) return 0;
        if (v > 65536) return 65536;
        return v;
    endfunction

    task automatic report(string what, result_t want, result_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s: expected kind=%0d idx=%0d x=%0d y=%0d u=%0d v=%0d last=%0d",
                $time, what, want.item_kind, want.index_value, want.vert_x, want.vert_y,
                want.tex_u, want.tex_v, want.last);
            $display("    got kind=%0d idx=%0d x=%0d y=%0d u=%0d v=%0d last=%0d",
                got.item_kind, got.index_value, got.vert_x, got.vert_y,
                got.tex_u, got.tex_v, got.last);
        end
    endtask

    task automatic add_expected(result_t r);
        if (exp_fill == EXP_DEPTH)
            report("expected item overflow", r, '0);
        else
        begin
            exp_buf[exp_wr_ptr] = r;
            exp_wr_ptr = exp_wr_ptr + 4'd1;
            exp_fill++;
        end
    endtask

    task automatic apply_command(cmd_t c);
        glyph_t  g;
        longint  k, tw, th, x0, x1, y0, y1, u0, u1, v0, v1;
        longint  px [4], py [4], pu [4], pv [4];
        result_t r;
        int      i;
        case (c.opcode)
            OP_LOAD:
            begin
                if (!glyph_loaded[c.char_code])
                begin
                    g.ax = c.atlas_x;
                    g.gw = c.glyph_w;
                    g.gh = c.glyph_h;
                    g.ay = longint'(tex_h) - longint'(c.atlas_y) - g.gh;
                    g.bx = c.bearing_x;
                    g.cw = c.cell_w;
                    g.ch = c.cell_h;
                    g.oy = g.ch - g.gh - longint'(c.bearing_y);
                    glyphs[c.char_code] = g;
                    glyph_loaded[c.char_code] = 1'b1;
                end
            end
            OP_START:
            begin
                pen_x = c.start_x;
                pen_y = c.start_y;
                vtx_count = '0;
            end
            OP_DRAW:
            begin
                if (glyph_loaded[c.char_code] && glyphs[c.char_code].ch != 0)
                begin
                    g = glyphs[c.char_code];
                    k = longint'(txt_h) * 16;
                    tw = (tex_w != 0) ? longint'(tex_w) : 1;
                    th = (tex_h != 0) ? longint'(tex_h) : 1;
                    x0 = round_div(g.bx * k, g.ch);
                    x1 = round_div((g.bx + g.gw) * k, g.ch);
                    y0 = round_div(g.oy * k, g.ch);
                    y1 = round_div((g.oy + g.gh) * k, g.ch);
                    u0 = round_div(g.ax * 65536, tw);
                    u1 = round_div((g.ax + g.gw) * 65536, tw);
                    v0 = round_div(g.ay * 65536, th);
                    v1 = round_div((g.ay + g.gh) * 65536, th);
                    px = '{x0, x0, x1, x1};
                    py = '{y1, y0, y1, y0};
                    pu = '{u0, u0, u1, u1};
                    pv = '{v1, v0, v1, v0};
                    for (i = 0; i < 6; i++)
                    begin
                        r = '0;
                        r.item_kind = KIND_INDEX;
                        r.index_value = vtx_count + ((i == 1 || i == 4) ? 16'd1 :
                                        (i == 2 || i == 3) ? 16'd2 :
                                        (i == 5) ? 16'd3 : 16'd0);
                        add_expected(r);
                    end
                    for (i = 0; i < 4; i++)
                    begin
                        r = '0;
                        r.item_kind = KIND_VERTEX;
                        r.vert_x = 24'(clamp_pos(pen_x + px[i]));
                        r.vert_y = 24'(clamp_pos(pen_y + py[i]));
                        r.tex_u = 17'(clamp_uv(pu[i]));
                        r.tex_v = 17'(clamp_uv(pv[i]));
                        r.last = (i == 3);
                        add_expected(r);
                    end
                    vtx_count = vtx_count + 16'd4;
                    pen_x = clamp_pos(pen_x + round_div(g.cw * k, g.ch));
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            foreach (glyph_loaded[i])
                glyph_loaded[i] = 1'b0;
            pen_x = 0;
            pen_y = 0;
            vtx_count = '0;
            tex_w = 13'd256;
            tex_h = 13'd256;
            txt_h = 16'd256;
            exp_wr_ptr = '0;
            exp_rd_ptr = '0;
            exp_fill = 0;
        end
        else
        begin
            if (strobe)
            begin
                if (exp_fill == 0)
                    report("unexpected result", '0, result);
                else
                begin
                    want = exp_buf[exp_rd_ptr];
                    exp_rd_ptr = exp_rd_ptr + 4'd1;
                    exp_fill--;
                    if (result.item_kind !== want.item_kind
                        || result.index_value !== want.index_value
                        || result.vert_x !== want.vert_x
                        || result.vert_y !== want.vert_y
                        || result.tex_u !== want.tex_u
                        || result.tex_v !== want.tex_v
                        || result.last !== want.last)
                        report("result mismatch", want, result);
                end
            end
            if (start && !busy)
                apply_command(cmd);
            if (wr_en)
            begin
                case (wr_index)
                    REG_TEX_WIDTH:   tex_w = wr_data[12:0];
                    REG_TEX_HEIGHT:  tex_h = wr_data[12:0];
                    REG_TEXT_HEIGHT: txt_h = wr_data;
                    default:
                    begin
                    end
                endcase
            end
        end
        pending = exp_fill;
    end

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

endmodule

// ===== dv/glyph_quad_generator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_quad_generator_top_tb
// Stimulus and verdict for the glyph quad generator. A directed run covers
// field extremes, duplicate loads, unknown codes, zero cell height, the
// unused opcode and pen saturation; random phases under several register
// settings follow, sent in bursts with random gaps (one phase has none).
// ----------------------------------------------------------------------------
module glyph_quad_generator_top_tb
    import gqg_pkg::*;
;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int CMD_W       = $bits(cmd_t);

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        strobe;
    result_t     result;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [15:0] wr_data;
    int          fail_count;
    int          pending;
    int          cycles;
    bit          loaded [256];

    glyph_quad_generator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .strobe   (strobe),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    glyph_quad_generator_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .strobe     (strobe),
        .result     (result),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic cmd_t noise_cmd();
        cmd_t c;
        c = CMD_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        return c;
    endfunction

    function automatic cmd_t load_cmd(int code, int ax, int ay, int gw, int gh,
                                      int bx, int by, int cw, int ch);
        cmd_t c;
        c = noise_cmd();
        c.opcode = OP_LOAD;
        c.char_code = 8'(code);
        c.atlas_x = 12'(ax);
        c.atlas_y = 12'(ay);
        c.glyph_w = 12'(gw);
        c.glyph_h = 12'(gh);
        c.bearing_x = 12'(bx);
        c.bearing_y = 12'(by);
        c.cell_w = 12'(cw);
        c.cell_h = 12'(ch);
        return c;
    endfunction

    function automatic cmd_t pen_cmd(int x, int y);
        cmd_t c;
        c = noise_cmd();
        c.opcode = OP_START;
        c.start_x = 24'(x);
        c.start_y = 24'(y);
        return c;
    endfunction

    function automatic cmd_t draw_cmd(int code);
        cmd_t c;
        c = noise_cmd();
        c.opcode = OP_DRAW;
        c.char_code = 8'(code);
        return c;
    endfunction

    task automatic send(cmd_t c);
        start <= 1'b1;
        cmd <= c;
        if (c.opcode == OP_LOAD)
            loaded[c.char_code] = 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_registers(logic [15:0] tw, logic [15:0] th, logic [15:0] txt);
        wr_en <= 1'b1;
        wr_index <= REG_TEX_WIDTH;
        wr_data <= tw;
        @(posedge clk);
        wr_index <= REG_TEX_HEIGHT;
        wr_data <= th;
        @(posedge clk);
        wr_index <= REG_TEXT_HEIGHT;
        wr_data <= txt;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    function automatic cmd_t random_glyph_cmd();
        cmd_t c;
        int   code;
        int   tries;
        c = noise_cmd();
        code = $urandom_range(0, 255);
        for (tries = 0; tries < 8 && loaded[code]; tries++)
            code = $urandom_range(0, 255);
        if ($urandom_range(0, 1) == 0)
            c = load_cmd(code, $urandom_range(0, 300), $urandom_range(0, 300),
                         $urandom_range(0, 40), $urandom_range(0, 40),
                         $urandom_range(0, 10) - 5, $urandom_range(0, 40) - 5,
                         $urandom_range(0, 48), $urandom_range(0, 48));
        else
        begin
            c.opcode = OP_LOAD;
            c.char_code = 8'(code);
        end
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        int   pick;
        int   code;
        cmd_t c;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return random_glyph_cmd();
        if (pick < 25)
        begin
            if ($urandom_range(0, 2) == 0)
                return pen_cmd($urandom, $urandom);
            return pen_cmd($urandom_range(0, 200000) - 100000,
                           $urandom_range(0, 200000) - 100000);
        end
        if (pick < 95)
        begin
            code = $urandom_range(0, 255);
            if ($urandom_range(0, 9) != 0)
                while (!loaded[code])
                    code = $urandom_range(0, 255);
            return draw_cmd(code);
        end
        c = noise_cmd();
        c.opcode = OP_UNUSED;
        return c;
    endfunction

    task automatic random_phase(int count, bit no_gaps);
        int burst;
        int gap;
        int n;
        burst = 0;
        for (n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 8);
                gap = no_gaps ? 0 : $urandom_range(0, 12);
                if (gap > 0 && n > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst--;
            send(random_cmd());
        end
        settle();
    endtask

    initial
    begin
        cmd_t odd;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        wr_en = 1'b0;
        wr_index = REG_TEX_WIDTH;
        wr_data = '0;
        cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(load_cmd(65, 10, 20, 8, 12, 1, 10, 9, 16));
        send(load_cmd(65, 99, 99, 30, 30, -3, 4, 31, 32));
        send(load_cmd(0, 4095, 4095, 4095, 4095, -2048, 2047, 4095, 4095));
        send(load_cmd(1, 0, 0, 0, 0, 2047, -2048, 0, 1));
        send(load_cmd(255, 5, 5, 5, 5, 0, 0, 5, 0));
        send(pen_cmd(0, 0));
        send(draw_cmd(65));
        send(draw_cmd(65));
        send(draw_cmd(0));
        send(draw_cmd(1));
        send(draw_cmd(255));
        send(draw_cmd(200));
        odd = noise_cmd();
        odd.opcode = OP_UNUSED;
        send(odd);
        send(pen_cmd(8388607, 8388607));
        send(draw_cmd(0));
        send(draw_cmd(1));
        send(pen_cmd(-8388608, -8388608));
        send(draw_cmd(0));
        send(draw_cmd(1));
        settle();

        set_registers(16'd4096, 16'd1, 16'd65535);
        send(draw_cmd(0));
        send(draw_cmd(65));
        settle();

        set_registers(16'd256, 16'd256, 16'd256);
        random_phase(70, 1'b0);
        set_registers(16'd4096, 16'd1, 16'd65535);
        random_phase(70, 1'b0);
        set_registers(16'd0, 16'd0, 16'd0);
        random_phase(70, 1'b1);
        set_registers(16'd1, 16'd4096, 16'd1);
        random_phase(70, 1'b0);
        set_registers(16'($urandom), 16'($urandom), 16'($urandom));
        random_phase(70, 1'b0);

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== glyph_quad_generator_top.f =====
+incdir+hw/rtl
hw/rtl/gqg_pkg.sv
hw/rtl/gqg_table.sv
hw/rtl/gqg_div.sv
hw/rtl/glyph_quad_generator_top.sv
dv/glyph_quad_generator_checker.sv
dv/glyph_quad_generator_top_tb.sv
